// ===== hw/rtl/pftd_pkg.sv =====
package pftd_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int NUM_W      = DATA_WIDTH - 1;
  localparam int SQ_W       = NUM_W + 1;
  localparam int CNT_W      = $clog2(NUM_W + 1);

  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

endpackage

// ===== hw/rtl/pftd_rem.sv =====
module pftd_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pftd_pkg::NUM_W-1:0]   dividend,
  input  logic [pftd_pkg::NUM_W-1:0]   divisor,
  output pftd_pkg::rem_stat_t          stat
);

  logic [pftd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pftd_pkg::NUM_W-1:0] q_r, q_nxt;
  logic [pftd_pkg::NUM_W-1:0] rem_r, rem_nxt;
  logic [pftd_pkg::NUM_W-1:0] d_r, d_nxt;
  logic [pftd_pkg::NUM_W:0]   rem_sh;
  logic [pftd_pkg::NUM_W:0]   rem_sub;
  pftd_pkg::rem_stat_t        stat_r, stat_nxt;

  assign rem_sh  = {rem_r, q_r[pftd_pkg::NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_comb begin
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    stat_nxt.done = 1'b0;
    stat_nxt.zero = stat_r.zero;
    if (cnt_r != '0) begin
      q_nxt   = {q_r[pftd_pkg::NUM_W-2:0], 1'b0};
      rem_nxt = (rem_sh >= {1'b0, d_r}) ? rem_sub[pftd_pkg::NUM_W-1:0]
                                        : rem_sh[pftd_pkg::NUM_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == pftd_pkg::CNT_W'(1)) begin
        stat_nxt.done = 1'b1;
        stat_nxt.zero = (rem_nxt == '0);
      end
    end else if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      d_nxt   = divisor;
      cnt_nxt = pftd_pkg::CNT_W'(pftd_pkg::NUM_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      stat_r.done <= 1'b0;
      stat_r.zero <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      stat_r <= stat_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign stat = stat_r;

endmodule

// ===== hw/rtl/prime_filter_trial_division.sv =====
// Flow: a value below 2 is judged not prime in the check state; otherwise k trial
// divisors (at most about sqrt(value)) are tried, a composite ending on a zero
// remainder and a prime on a failed square compare; each is a square compare step,
// an iterative remainder of DATA_WIDTH-1 steps and one step to pick up its flags.
// Throughput: one word in flight; busy stays high until its result strobes.
// Result strobes out_valid for one cycle; the receiver cannot stall; reset (rst_n) idles.
module prime_filter_trial_division (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [pftd_pkg::DATA_WIDTH-1:0] in_value,
  input  logic                                in_last,
  output logic                                out_valid,
  output logic signed [pftd_pkg::DATA_WIDTH-1:0] out_value_out,
  output logic                                out_is_prime,
  output logic                                out_last_out
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_TEST,
    S_WAIT
  } state_t;

  state_t                                    state_r;
  logic signed [pftd_pkg::DATA_WIDTH-1:0]    value_r;
  logic                                      last_r;
  logic [pftd_pkg::NUM_W-1:0]                d_r;
  logic [pftd_pkg::SQ_W-1:0]                 sq_r;
  logic                                      busy_r;
  logic                                      out_valid_r;
  logic signed [pftd_pkg::DATA_WIDTH-1:0]    out_value_r;
  logic                                      out_prime_r;
  logic                                      out_last_r;
  logic [pftd_pkg::NUM_W-1:0]                n;
  logic                                      sq_over;
  logic                                      rem_start;
  pftd_pkg::rem_stat_t                       rem_stat;

  assign n         = value_r[pftd_pkg::NUM_W-1:0];
  assign sq_over   = sq_r > {1'b0, n};
  assign rem_start = (state_r == S_TEST) && !sq_over;

  pftd_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (n),
    .divisor  (d_r),
    .stat     (rem_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            value_r <= in_value;
            last_r  <= in_last;
            busy_r  <= 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          d_r  <= pftd_pkg::NUM_W'(2);
          sq_r <= pftd_pkg::SQ_W'(4);
          if (value_r < pftd_pkg::DATA_WIDTH'(2)) begin
            out_valid_r <= 1'b1;
            out_value_r <= value_r;
            out_prime_r <= 1'b0;
            out_last_r  <= last_r;
            busy_r      <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_TEST;
          end
        end
        S_TEST: begin
          if (sq_over) begin
            out_valid_r <= 1'b1;
            out_value_r <= value_r;
            out_prime_r <= 1'b1;
            out_last_r  <= last_r;
            busy_r      <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rem_stat.done) begin
            if (rem_stat.zero) begin
              out_valid_r <= 1'b1;
              out_value_r <= value_r;
              out_prime_r <= 1'b0;
              out_last_r  <= last_r;
              busy_r      <= 1'b0;
              state_r     <= S_IDLE;
            end else begin
              // (d+1)^2 = d^2 + 2d + 1
              sq_r    <= sq_r + {d_r, 1'b1};
              d_r     <= d_r + 1'b1;
              state_r <= S_TEST;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy          = busy_r;
  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_is_prime  = out_prime_r;
  assign out_last_out  = out_last_r;

endmodule

// ===== hw/rtl/pftd_checker.sv =====
module pftd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [pftd_pkg::DATA_WIDTH-1:0] out_value_out,
  input logic                                out_is_prime,
  input logic                                out_last_out
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_prime_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_prime |->
      !out_value_out[pftd_pkg::DATA_WIDTH-1] &&
      (out_value_out[pftd_pkg::DATA_WIDTH-1:1] != '0) && !$isunknown(out_last_out))
    else $error("value below two flagged prime");

endmodule

bind prime_filter_trial_division pftd_checker u_pftd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_value_out (out_value_out),
  .out_is_prime  (out_is_prime),
  .out_last_out  (out_last_out)
);

// ===== verif/prime_filter_trial_division_tb.sv =====
module prime_filter_trial_division_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W          = pftd_pkg::DATA_WIDTH;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_WORDS = 100;

  typedef struct {
    logic signed [W-1:0] value;
    logic                prime;
    logic                last;
  } prime_verdict_t;

  typedef struct {
    logic signed [W-1:0] value;
    logic                last;
    logic                typed;
    logic                prime;
  } stim_row_t;

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic signed [W-1:0] in_value = '0;
  logic                in_last  = 1'b0;
  logic                out_valid;
  logic signed [W-1:0] out_value_out;
  logic                out_is_prime;
  logic                out_last_out;

  prime_verdict_t verdict_q[$];
  int err_count   = 0;
  int words_sent  = 0;
  int words_done  = 0;
  int primes_seen = 0;
  int lasts_seen  = 0;
  int idle_cycles = 0;

  stim_row_t directed_rows [17];

  prime_filter_trial_division i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_value_out(out_value_out),
    .out_is_prime (out_is_prime),
    .out_last_out (out_last_out)
  );

  always #6 clk = ~clk;

  function automatic logic is_prime_by_division(logic signed [W-1:0] v);
    int n;
    n = v;
    if (n < 2) return 1'b0;
    for (int d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: return W'($urandom_range(0, 400));
      4, 5:       return W'($urandom);
      6, 7:       return W'($urandom_range(30000, 32767) | 1);
      8:          return W'(-int'($urandom_range(1, 32768)));
      default:    return W'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d (t=%0t)", field, got, want, $time);
    err_count++;
  endtask

  // call at a rising edge; returns at the edge that accepts the word
  task automatic send_word(logic signed [W-1:0] v, logic l, logic typed, logic typed_prime);
    prime_verdict_t exp;
    start    <= 1'b1;
    in_value <= v;
    in_last  <= l;
    do @(posedge clk); while (busy !== 1'b0);
    exp.value = v;
    exp.last  = l;
    exp.prime = typed ? typed_prime : is_prime_by_division(v);
    verdict_q.push_back(exp);
    words_sent++;
  endtask

  task automatic idle_burst(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_verdicts();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    prime_verdict_t exp;
    if (rst_n && out_valid === 1'b1) begin
      words_done++;
      if (out_is_prime === 1'b1) primes_seen++;
      if (out_last_out === 1'b1) lasts_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected word, value", int'(out_value_out), 0);
      end else begin
        exp = verdict_q.pop_front();
        if (out_value_out !== exp.value)
          report_mismatch("value_out", int'(out_value_out), int'(exp.value));
        if (out_is_prime !== exp.prime)
          report_mismatch($sformatf("is_prime of %0d", exp.value), out_is_prime, exp.prime);
        if (out_last_out !== exp.last)
          report_mismatch("last_out", out_last_out, exp.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    directed_rows = '{
      '{16'sh8000, 1'b0, 1'b1, 1'b0},
      '{-16'sd1,   1'b0, 1'b1, 1'b0},
      '{16'sd0,    1'b0, 1'b1, 1'b0},
      '{16'sd1,    1'b1, 1'b1, 1'b0},
      '{16'sd2,    1'b0, 1'b1, 1'b1},
      '{16'sd3,    1'b0, 1'b1, 1'b1},
      '{16'sd4,    1'b0, 1'b1, 1'b0},
      '{16'sd5,    1'b0, 1'b0, 1'b0},
      '{16'sd9,    1'b0, 1'b0, 1'b0},
      '{16'sd25,   1'b1, 1'b0, 1'b0},
      '{16'sd169,  1'b0, 1'b0, 1'b0},
      '{16'sh5555, 1'b0, 1'b0, 1'b0},
      '{16'shAAAA, 1'b0, 1'b1, 1'b0},
      '{16'sd32749, 1'b0, 1'b0, 1'b0},
      '{16'sd32761, 1'b0, 1'b0, 1'b0},
      '{16'sh7FFF, 1'b1, 1'b0, 1'b0},
      '{16'sd17,   1'b1, 1'b0, 1'b0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].value, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].prime);
      if ($urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 6));
    end
    drain_verdicts();

    for (int n = 0; n < RAND_WORDS; n++) begin
      send_word(pick_value(), $urandom_range(0, 7) == 0, 1'b0, 1'b0);
      if (n == RAND_WORDS / 2)
        drain_verdicts();
      else if (n < RAND_WORDS - 20 && $urandom_range(0, 2) == 0)
        idle_burst($urandom_range(1, 6));
    end

    drain_verdicts();
    repeat (40) @(posedge clk);

    $display("ran %0d words (%0d directed), %0d results back", words_sent,
             $size(directed_rows), words_done);
    $display("%0d judged prime, %0d carried the last flag", primes_seen, lasts_seen);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
